// ===== rtl/tsa_pkg.sv =====
// Shared constants, register indexes and control types of the threshold sweep block.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
`default_nettype none

package tsa_pkg;

    localparam int STEPS_W = 11;
    localparam int EVAL_W  = 16;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 16;

    localparam logic [STEPS_W-1:0] STEPS_ONE   = 11'd1;
    localparam logic [STEPS_W-1:0] STEPS_MAX   = 11'd1024;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 11'd100;

    localparam logic [CFG_AW-1:0] REG_SWEEP_STEPS = 2'd0;
    localparam logic [CFG_AW-1:0] REG_EVAL_THR    = 2'd1;

    typedef struct packed {
        logic shift;
        logic stream;
    } t_cell_ctrl;

    typedef struct packed {
        logic valid;
        logic is_eval;
    } t_entry_tag;

endpackage

`default_nettype wire

// ===== rtl/tsa_cell.sv =====
// One cell of the counting chain: holds a threshold and its correct-pair count.
// Depends on tsa_pkg (t_cell_ctrl, t_entry_tag).
`timescale 1ns / 1ps
`default_nettype none

module tsa_cell
    import tsa_pkg::*;
#(
    parameter int SIM_WIDTH = 16,
    parameter int TW        = 16,
    parameter int CW        = 13
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  t_cell_ctrl                 i_ctrl,
    input  wire logic signed [TW-1:0]  i_thr,
    input  t_entry_tag                 i_tag,
    input  wire logic [CW-1:0]         i_cnt,
    output logic signed [TW-1:0]       o_thr,
    output t_entry_tag                 o_tag,
    output logic [CW-1:0]              o_cnt,
    input  wire logic signed [SIM_WIDTH-1:0] i_sim,
    input  wire                        i_lab,
    input  wire                        i_pv,
    output logic signed [SIM_WIDTH-1:0] o_sim,
    output logic                       o_lab,
    output logic                       o_pv
);

    logic signed [TW-1:0]        r_thr;
    t_entry_tag                  r_tag;
    logic [CW-1:0]               r_cnt;
    logic signed [SIM_WIDTH-1:0] r_sim;
    logic                        r_lab;
    logic                        r_pv;
    logic                        hit;

    assign hit = i_pv & r_tag.valid & (($signed(TW'(i_sim)) >= r_thr) == i_lab);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
            r_pv  <= 1'b0;
        end else begin
            r_pv <= i_pv & i_ctrl.stream;
            if (i_ctrl.shift) begin
                r_tag <= i_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sim <= i_sim;
        r_lab <= i_lab;
        if (i_ctrl.shift) begin
            r_thr <= i_thr;
            r_cnt <= i_cnt;
        end else if (i_ctrl.stream && hit) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_thr = r_thr;
    assign o_tag = r_tag;
    assign o_cnt = r_cnt;
    assign o_sim = r_sim;
    assign o_lab = r_lab;
    assign o_pv  = r_pv;

endmodule

`default_nettype wire

// ===== rtl/tsa_thr_gen.sv =====
// Threshold sequence source: divides the span once, then steps min + floor(span*s/steps).
// Appends the evaluation threshold when it is nonzero. Depends on tsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsa_thr_gen
    import tsa_pkg::*;
#(
    parameter int SIM_WIDTH = 16,
    parameter int TW        = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire logic signed [SIM_WIDTH-1:0] i_min,
    input  wire logic signed [SIM_WIDTH-1:0] i_max,
    input  wire logic [STEPS_W-1:0]          i_steps,
    input  wire logic signed [EVAL_W-1:0]    i_eval,
    input  wire                              i_take,
    output logic                             o_busy,
    output t_entry_tag                       o_tag,
    output logic signed [TW-1:0]             o_thr
);

    localparam int BW = $clog2(SIM_WIDTH + 1);

    logic                        r_busy;
    logic [BW-1:0]               r_bits;
    logic [SIM_WIDTH-1:0]        r_dvd;
    logic [STEPS_W:0]            r_rem;
    logic [STEPS_W-1:0]          r_steps;
    logic signed [SIM_WIDTH-1:0] r_min;
    logic signed [EVAL_W-1:0]    r_eval;
    logic                        r_coll;
    logic                        r_sw_left;
    logic                        r_ev_left;
    logic [STEPS_W-1:0]          r_s;
    logic [SIM_WIDTH-1:0]        r_acc;
    logic [STEPS_W-1:0]          r_racc;

    logic [STEPS_W-1:0]          steps_eff;
    logic [STEPS_W:0]            rem_sh;
    logic                        rem_ge;
    logic [STEPS_W:0]            rsum;
    logic                        rsum_ge;
    logic signed [SIM_WIDTH-1:0] sw_thr;

    always_comb begin
        if (i_steps == '0) begin
            steps_eff = STEPS_ONE;
        end else if (i_steps > STEPS_MAX) begin
            steps_eff = STEPS_MAX;
        end else begin
            steps_eff = i_steps;
        end
    end

    assign rem_sh  = {r_rem[STEPS_W-1:0], r_dvd[SIM_WIDTH-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_steps};
    assign rsum    = {1'b0, r_racc} + {1'b0, r_rem[STEPS_W-1:0]};
    assign rsum_ge = rsum >= {1'b0, r_steps};
    assign sw_thr  = r_min + $signed(r_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_sw_left <= 1'b0;
            r_ev_left <= 1'b0;
        end else if (i_start) begin
            r_busy    <= 1'b1;
            r_sw_left <= 1'b1;
            r_ev_left <= (i_eval != '0);
        end else if (r_busy) begin
            if (r_bits == BW'(1)) begin
                r_busy <= 1'b0;
            end
        end else if (i_take) begin
            if (r_sw_left) begin
                if (r_coll || (r_s == r_steps)) begin
                    r_sw_left <= 1'b0;
                end
            end else begin
                r_ev_left <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bits  <= BW'(SIM_WIDTH);
            r_dvd   <= SIM_WIDTH'(i_max - i_min);
            r_rem   <= '0;
            r_steps <= steps_eff;
            r_min   <= i_min;
            r_eval  <= i_eval;
            r_coll  <= (i_max == i_min);
            r_s     <= '0;
            r_acc   <= '0;
            r_racc  <= '0;
        end else if (r_busy) begin
            r_bits <= r_bits - 1'b1;
            if (rem_ge) begin
                r_rem <= rem_sh - {1'b0, r_steps};
                r_dvd <= {r_dvd[SIM_WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_dvd <= {r_dvd[SIM_WIDTH-2:0], 1'b0};
            end
        end else if (i_take && r_sw_left) begin
            r_s <= r_s + 1'b1;
            if (rsum_ge) begin
                r_racc <= STEPS_W'(rsum - {1'b0, r_steps});
                r_acc  <= r_acc + r_dvd + 1'b1;
            end else begin
                r_racc <= rsum[STEPS_W-1:0];
                r_acc  <= r_acc + r_dvd;
            end
        end
    end

    always_comb begin
        o_tag.valid   = r_sw_left | r_ev_left;
        o_tag.is_eval = ~r_sw_left;
        if (r_sw_left) begin
            o_thr = r_coll ? '0 : TW'(sw_thr);
        end else begin
            o_thr = TW'(r_eval);
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

// ===== rtl/threshold_sweep_accuracy.sv =====
// Sweep: after the last word, T thresholds (sweep_steps+1, with sweep_steps clamped to
// 1..1024, plus one when eval_threshold != 0) are tested in P = ceil(T/NCELLS) passes;
// each pass reloads the cell chain and streams the pair memory once.
// Throughput: one pair word per cycle while loading; no input is taken during the sweep.
// Reset (synchronous, active low) empties the set and restores sweep_steps 100, eval 0.
// Depends on tsa_pkg, tsa_thr_gen, tsa_cell.
`timescale 1ns / 1ps
`default_nettype none

module threshold_sweep_accuracy
    import tsa_pkg::*;
#(
    parameter int MAX_PAIRS = 4096,
    parameter int SIM_WIDTH = 16,
    parameter int NCELLS    = 16
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // [SIM_WIDTH-1:0] similarity, rest zero
    input  wire logic [((SIM_WIDTH+7)/8)*8-1:0]    i_s_axis_tdata,
    // [0] label
    input  wire                                    i_s_axis_tuser,
    input  wire                                    i_s_axis_tlast,
    output logic                                   o_m_axis_tvalid,
    input  wire                                    i_m_axis_tready,
    // best_threshold, best_correct, eval_correct, pair_count, positive_count, zero pad
    output logic [((SIM_WIDTH+4*$clog2(MAX_PAIRS+1)+7)/8)*8-1:0] o_m_axis_tdata,
    // [0] collapsed, [1] overflow
    output logic [1:0]                             o_m_axis_tuser,
    input  wire                                    i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [CFG_AW-1:0]                 i_cfg_addr,
    input  wire logic [CFG_DW-1:0]                 i_cfg_data
);

    localparam int CW   = $clog2(MAX_PAIRS + 1);
    localparam int AW   = $clog2(MAX_PAIRS);
    localparam int TW   = (SIM_WIDTH > EVAL_W) ? SIM_WIDTH : EVAL_W;
    localparam int CNTW = $clog2(MAX_PAIRS + NCELLS);
    localparam int ODW  = ((SIM_WIDTH + 4*CW + 7) / 8) * 8;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_START  = 6'b000010,
        S_DIV    = 6'b000100,
        S_SHIFT  = 6'b001000,
        S_STREAM = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [STEPS_W-1:0]          r_steps;
    logic signed [EVAL_W-1:0]    r_eval;

    logic [CW-1:0]               r_stored;
    logic signed [SIM_WIDTH-1:0] r_min;
    logic signed [SIM_WIDTH-1:0] r_max;
    logic [CW-1:0]               r_pos;
    logic                        r_ovf;

    logic [SIM_WIDTH:0]          mem [MAX_PAIRS];
    logic signed [SIM_WIDTH-1:0] r_rd_sim;
    logic                        r_rd_lab;
    logic                        r_rd_v;

    logic [CNTW-1:0]             r_cnt;
    logic                        r_live;
    logic                        r_have;
    logic signed [TW-1:0]        r_best_thr;
    logic [CW-1:0]               r_best_cnt;
    logic [CW-1:0]               r_evc;

    logic                        r_o_valid;
    logic signed [SIM_WIDTH-1:0] r_o_thr;
    logic [CW-1:0]               r_o_bcnt;
    logic [CW-1:0]               r_o_ecnt;
    logic [CW-1:0]               r_o_pcnt;
    logic [CW-1:0]               r_o_pos;
    logic                        r_o_coll;
    logic                        r_o_ovf;

    logic                        in_acc;
    logic signed [SIM_WIDTH-1:0] in_sim;
    logic                        room;
    logic                        out_free;
    logic                        shift_end;
    logic                        stream_end;
    logic                        gen_busy;
    t_cell_ctrl                  ctrl;

    logic signed [TW-1:0]        w_thr [NCELLS+1];
    t_entry_tag                  w_tag [NCELLS+1];
    logic [CW-1:0]               w_cnt [NCELLS+1];
    logic signed [SIM_WIDTH-1:0] w_sim [NCELLS+1];
    logic                        w_lab [NCELLS+1];
    logic                        w_pv  [NCELLS+1];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign in_acc          = i_s_axis_tvalid & o_s_axis_tready;
    assign in_sim          = $signed(i_s_axis_tdata[SIM_WIDTH-1:0]);
    assign room            = (r_stored != CW'(MAX_PAIRS));
    assign out_free        = ~r_o_valid | i_m_axis_tready;
    assign shift_end       = (r_cnt == CNTW'(NCELLS - 1));
    assign stream_end      = (r_cnt == CNTW'(r_stored) + CNTW'(NCELLS - 1));
    assign ctrl.shift      = (r_state == S_SHIFT);
    assign ctrl.stream     = (r_state == S_STREAM);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= STEPS_RESET;
            r_eval  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_SWEEP_STEPS: r_steps <= i_cfg_data[STEPS_W-1:0];
                REG_EVAL_THR:    r_eval  <= $signed(i_cfg_data[EVAL_W-1:0]);
                default: ;
            endcase
        end
    end

    // pair memory
    always_ff @(posedge i_clk) begin
        if (in_acc && room) begin
            mem[r_stored[AW-1:0]] <= {i_s_axis_tuser, in_sim};
        end
        r_rd_sim <= $signed(mem[r_cnt[AW-1:0]][SIM_WIDTH-1:0]);
        r_rd_lab <= mem[r_cnt[AW-1:0]][SIM_WIDTH];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_acc && i_s_axis_tlast) n_state = S_START;
            S_START:  n_state = S_DIV;
            S_DIV:    if (!gen_busy) n_state = S_SHIFT;
            S_SHIFT:  if (shift_end) n_state = (r_live | w_tag[0].valid) ? S_STREAM : S_FINISH;
            S_STREAM: if (stream_end) n_state = S_SHIFT;
            S_FINISH: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_stored <= '0;
            r_min    <= {1'b0, {(SIM_WIDTH-1){1'b1}}};
            r_max    <= {1'b1, {(SIM_WIDTH-1){1'b0}}};
            r_pos    <= '0;
            r_ovf    <= 1'b0;
            r_cnt    <= '0;
            r_live   <= 1'b0;
            r_have   <= 1'b0;
            r_rd_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= ctrl.stream & (r_cnt < CNTW'(r_stored));
            if (in_acc) begin
                if (room) begin
                    r_stored <= r_stored + 1'b1;
                    if (in_sim < r_min) r_min <= in_sim;
                    if (in_sim > r_max) r_max <= in_sim;
                    if (i_s_axis_tuser) r_pos <= r_pos + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (r_state == S_START) begin
                r_have <= 1'b0;
                r_cnt  <= '0;
                r_live <= 1'b0;
            end
            if (ctrl.shift) begin
                if (shift_end) begin
                    r_cnt  <= '0;
                    r_live <= 1'b0;
                end else begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_live <= r_live | w_tag[0].valid;
                end
                if (w_tag[NCELLS].valid && !w_tag[NCELLS].is_eval &&
                    (!r_have || (w_cnt[NCELLS] > r_best_cnt))) begin
                    r_have <= 1'b1;
                end
            end
            if (ctrl.stream) begin
                r_cnt <= stream_end ? '0 : r_cnt + 1'b1;
            end
            if (r_state == S_FINISH && out_free) begin
                r_stored <= '0;
                r_min    <= {1'b0, {(SIM_WIDTH-1){1'b1}}};
                r_max    <= {1'b1, {(SIM_WIDTH-1){1'b0}}};
                r_pos    <= '0;
                r_ovf    <= 1'b0;
            end
        end
    end

    // collect records leaving the chain tail
    always_ff @(posedge i_clk) begin
        if (ctrl.shift && w_tag[NCELLS].valid) begin
            if (w_tag[NCELLS].is_eval) begin
                r_evc <= w_cnt[NCELLS];
            end else if (!r_have || (w_cnt[NCELLS] > r_best_cnt)) begin
                r_best_cnt <= w_cnt[NCELLS];
                r_best_thr <= w_thr[NCELLS];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_FINISH && out_free) begin
            r_o_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && out_free) begin
            r_o_thr  <= r_best_thr[SIM_WIDTH-1:0];
            r_o_bcnt <= r_best_cnt;
            r_o_ecnt <= (r_eval != '0) ? r_evc : r_best_cnt;
            r_o_pcnt <= r_stored;
            r_o_pos  <= r_pos;
            r_o_coll <= (r_max == r_min);
            r_o_ovf  <= r_ovf;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = ODW'({r_o_pos, r_o_pcnt, r_o_ecnt, r_o_bcnt, r_o_thr});
    assign o_m_axis_tuser  = {r_o_ovf, r_o_coll};

    tsa_thr_gen #(
        .SIM_WIDTH (SIM_WIDTH),
        .TW        (TW)
    ) u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START),
        .i_min   (r_min),
        .i_max   (r_max),
        .i_steps (r_steps),
        .i_eval  (r_eval),
        .i_take  (ctrl.shift),
        .o_busy  (gen_busy),
        .o_tag   (w_tag[0]),
        .o_thr   (w_thr[0])
    );

    assign w_cnt[0] = '0;
    assign w_sim[0] = r_rd_sim;
    assign w_lab[0] = r_rd_lab;
    assign w_pv[0]  = r_rd_v;

    for (genvar k = 0; k < NCELLS; k++) begin : g_cell
        tsa_cell #(
            .SIM_WIDTH (SIM_WIDTH),
            .TW        (TW),
            .CW        (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_thr   (w_thr[k]),
            .i_tag   (w_tag[k]),
            .i_cnt   (w_cnt[k]),
            .o_thr   (w_thr[k+1]),
            .o_tag   (w_tag[k+1]),
            .o_cnt   (w_cnt[k+1]),
            .i_sim   (w_sim[k]),
            .i_lab   (w_lab[k]),
            .i_pv    (w_pv[k]),
            .o_sim   (w_sim[k+1]),
            .o_lab   (w_lab[k+1]),
            .o_pv    (w_pv[k+1])
        );
    end

    a_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= CW'(MAX_PAIRS))
        else $error("stored pair count beyond capacity");

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_s_axis_tlast) |=> (r_state == S_START))
        else $error("last word did not start the sweep");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> ((r_o_bcnt <= r_o_pcnt) && (r_o_ecnt <= r_o_pcnt) && (r_o_pcnt != '0)))
        else $error("result counts inconsistent with pair count");

    a_chain_flushed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.shift |=> !w_pv[NCELLS])
        else $error("pair still live at chain tail during reload");

endmodule

`default_nettype wire
